// File: sv/shape_pair_mtv_core_assert.svh
// Assertion macros shared by the shape pair core.
`ifndef SHAPE_PAIR_MTV_CORE_ASSERT_SVH
`define SHAPE_PAIR_MTV_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SPM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shape_pair_mtv_core: implication check failed");

// Next-cycle implication, also checked across reset.
`define SPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("shape_pair_mtv_core: next-cycle check failed");

`endif

// File: sv/spm_pkg.sv
package spm_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int MAG_W = COORD_WIDTH + 1;
  localparam int PEN_W = COORD_WIDTH + 2;
  localparam int SQ_W = 2 * MAG_W;
  localparam int ROOT_W = MAG_W;

  typedef enum logic [1:0] {
    MODE_BOX_BOX   = 2'd0,
    MODE_CIRC_CIRC = 2'd1,
    MODE_CIRC_BOX  = 2'd2
  } mode_t;

  // Per-item control and operands that ride alongside the root and divide pipes.
  typedef struct packed {
    logic             hit;
    logic             use_div;
    logic             neg;
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] dir_x;
    logic [MAG_W-1:0] dir_y;
    logic [MAG_W-1:0] r;
    logic [MAG_W-1:0] ex;
    logic [MAG_W-1:0] ey;
  } side_t;

endpackage

// File: sv/spm_front.sv
module spm_front import spm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          pair_valid,
  input  logic                          kind_a,
  input  logic signed [COORD_WIDTH-1:0] pos_a_x,
  input  logic signed [COORD_WIDTH-1:0] pos_a_y,
  input  logic [COORD_WIDTH-2:0]        size_a_x,
  input  logic [COORD_WIDTH-2:0]        size_a_y,
  input  logic                          kind_b,
  input  logic signed [COORD_WIDTH-1:0] pos_b_x,
  input  logic signed [COORD_WIDTH-1:0] pos_b_y,
  input  logic [COORD_WIDTH-2:0]        size_b_x,
  input  logic [COORD_WIDTH-2:0]        size_b_y,
  output logic                          ds_valid,
  output side_t                         ds_side,
  output logic [SQ_W-1:0]               ds
);

  // Stage A: pick the shape roles and take center differences.
  logic                     a_valid;
  mode_t                    a_mode, mode_next;
  logic                     a_neg;
  logic signed [DIFF_W-1:0] a_dx, a_dy, dx_next, dy_next;
  logic [COORD_WIDTH-1:0]   a_hx, a_hy, hx_next, hy_next;
  logic [MAG_W-1:0]         a_r, r_next;
  logic signed [DIFF_W-1:0] ax_w, ay_w, bx_w, by_w;
  logic                     circ_a_only;

  assign ax_w = DIFF_W'(pos_a_x);
  assign ay_w = DIFF_W'(pos_a_y);
  assign bx_w = DIFF_W'(pos_b_x);
  assign by_w = DIFF_W'(pos_b_y);
  assign circ_a_only = kind_a & ~kind_b;

  // The offset always points from the box (or shape a) toward the circle.
  assign dx_next = circ_a_only ? ax_w - bx_w : bx_w - ax_w;
  assign dy_next = circ_a_only ? ay_w - by_w : by_w - ay_w;

  always_comb begin
    unique case ({kind_a, kind_b})
      2'b00: mode_next = MODE_BOX_BOX;
      2'b11: mode_next = MODE_CIRC_CIRC;
      2'b01, 2'b10: mode_next = MODE_CIRC_BOX;
    endcase
  end

  always_comb begin
    if (mode_next == MODE_BOX_BOX) begin
      hx_next = COORD_WIDTH'(size_a_x) + COORD_WIDTH'(size_b_x);
      hy_next = COORD_WIDTH'(size_a_y) + COORD_WIDTH'(size_b_y);
    end else begin
      hx_next = kind_a ? COORD_WIDTH'(size_b_x) : COORD_WIDTH'(size_a_x);
      hy_next = kind_a ? COORD_WIDTH'(size_b_y) : COORD_WIDTH'(size_a_y);
    end
    if (mode_next == MODE_CIRC_CIRC) begin
      r_next = MAG_W'(size_a_x) + MAG_W'(size_b_x);
    end else begin
      r_next = kind_a ? MAG_W'(size_a_x) : MAG_W'(size_b_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode <= mode_next;
      a_neg  <= circ_a_only;
      a_dx   <= dx_next;
      a_dy   <= dy_next;
      a_hx   <= hx_next;
      a_hy   <= hy_next;
      a_r    <= r_next;
    end
  end

  // Stage B: per-axis penetration and the offset outside the box.
  logic                    b_valid;
  mode_t                   b_mode;
  logic                    b_neg, b_sx, b_sy;
  logic signed [PEN_W-1:0] b_pen_x, b_pen_y, pen_x_next, pen_y_next;
  logic [MAG_W-1:0]        b_ex, b_ey, b_r, ex_next, ey_next, mag_x, mag_y;

  assign mag_x = a_dx[DIFF_W-1] ? -a_dx : a_dx;
  assign mag_y = a_dy[DIFF_W-1] ? -a_dy : a_dy;
  assign pen_x_next = $signed({2'b00, a_hx}) - $signed({1'b0, mag_x});
  assign pen_y_next = $signed({2'b00, a_hy}) - $signed({1'b0, mag_y});

  always_comb begin
    unique case (a_mode)
      MODE_CIRC_CIRC: begin
        ex_next = mag_x;
        ey_next = mag_y;
      end
      MODE_CIRC_BOX: begin
        // Distance past the box face, zero when inside the slab.
        ex_next = pen_x_next[PEN_W-1] ? MAG_W'(-pen_x_next) : '0;
        ey_next = pen_y_next[PEN_W-1] ? MAG_W'(-pen_y_next) : '0;
      end
      default: begin
        ex_next = '0;
        ey_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mode  <= a_mode;
      b_neg   <= a_neg;
      b_sx    <= a_dx[DIFF_W-1];
      b_sy    <= a_dy[DIFF_W-1];
      b_pen_x <= pen_x_next;
      b_pen_y <= pen_y_next;
      b_ex    <= ex_next;
      b_ey    <= ey_next;
      b_r     <= a_r;
    end
  end

  // Stage C: squares.
  logic                    c_valid;
  mode_t                   c_mode;
  logic                    c_neg, c_sx, c_sy;
  logic signed [PEN_W-1:0] c_pen_x, c_pen_y;
  logic [MAG_W-1:0]        c_ex, c_ey, c_r;
  logic [SQ_W-1:0]         c_sq_x, c_sq_y, c_sq_r, sq_x_next, sq_y_next, sq_r_next;

  assign sq_x_next = SQ_W'(b_ex) * SQ_W'(b_ex);
  assign sq_y_next = SQ_W'(b_ey) * SQ_W'(b_ey);
  assign sq_r_next = SQ_W'(b_r) * SQ_W'(b_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mode  <= b_mode;
      c_neg   <= b_neg;
      c_sx    <= b_sx;
      c_sy    <= b_sy;
      c_pen_x <= b_pen_x;
      c_pen_y <= b_pen_y;
      c_ex    <= b_ex;
      c_ey    <= b_ey;
      c_r     <= b_r;
      c_sq_x  <= sq_x_next;
      c_sq_y  <= sq_y_next;
      c_sq_r  <= sq_r_next;
    end
  end

  // Stage D: squared distance, hit test and the vector for cases without a divide.
  logic [SQ_W-1:0] ds_next;
  logic            zero;
  side_t           side_next;

  assign ds_next = c_sq_x + c_sq_y;
  assign zero = (ds_next == '0);

  always_comb begin
    side_next = '0;
    side_next.neg = c_neg;
    side_next.sx = c_sx;
    side_next.sy = c_sy;
    side_next.r = c_r;
    side_next.ex = c_ex;
    side_next.ey = c_ey;
    unique case (c_mode)
      MODE_BOX_BOX: begin
        side_next.hit = !c_pen_x[PEN_W-1] && (c_pen_x != '0) &&
                        !c_pen_y[PEN_W-1] && (c_pen_y != '0);
        if (c_pen_x < c_pen_y) begin
          side_next.dir_x = MAG_W'(c_pen_x);
        end else begin
          side_next.dir_y = MAG_W'(c_pen_y);
        end
      end
      MODE_CIRC_CIRC: begin
        side_next.hit = ds_next < c_sq_r;
        side_next.use_div = !zero;
        if (zero) begin
          side_next.dir_x = c_r;
          side_next.sx = 1'b0;
        end
      end
      MODE_CIRC_BOX: begin
        side_next.hit = ds_next <= c_sq_r;
        side_next.use_div = !zero;
        // Center inside the box: leave through the nearest face.
        if (c_pen_x < c_pen_y) begin
          side_next.dir_x = MAG_W'(c_pen_x) + c_r;
        end else begin
          side_next.dir_y = MAG_W'(c_pen_y) + c_r;
        end
      end
      default: begin
        side_next.hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ds_valid <= 1'b0;
    end else if (en) begin
      ds_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_side <= side_next;
      ds      <= ds_next;
    end
  end

endmodule

// File: sv/spm_sqrt.sv
module spm_sqrt import spm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              ds_valid,
  input  side_t             ds_side,
  input  logic [SQ_W-1:0]   ds,
  output logic              root_valid,
  output side_t             root_side,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem      [ROOT_W];
  logic [REM_W-1:0]  rem_in   [ROOT_W];
  logic [REM_W-1:0]  rem_next [ROOT_W];
  logic [ROOT_W-1:0] acc      [ROOT_W];
  logic [ROOT_W-1:0] acc_in   [ROOT_W];
  logic [ROOT_W-1:0] acc_next [ROOT_W];
  logic [SQ_W-1:0]   rad      [ROOT_W];
  logic [SQ_W-1:0]   rad_in   [ROOT_W];
  logic [SQ_W-1:0]   rad_next [ROOT_W];
  logic [REM_W+1:0]  part     [ROOT_W];
  logic [REM_W+1:0]  trial    [ROOT_W];
  logic              fit      [ROOT_W];
  logic              vld      [ROOT_W];
  logic              vld_in   [ROOT_W];
  side_t             side     [ROOT_W];
  side_t             side_in  [ROOT_W];

  // One result bit per stage, two radicand bits shifted in each time.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign acc_in[k]  = '0;
      assign rad_in[k]  = ds;
      assign vld_in[k]  = ds_valid;
      assign side_in[k] = ds_side;
    end else begin : g_rest
      assign rem_in[k]  = rem[k-1];
      assign acc_in[k]  = acc[k-1];
      assign rad_in[k]  = rad[k-1];
      assign vld_in[k]  = vld[k-1];
      assign side_in[k] = side[k-1];
    end

    assign part[k]     = {rem_in[k], rad_in[k][SQ_W-1 -: 2]};
    assign trial[k]    = {2'b00, acc_in[k], 2'b01};
    assign fit[k]      = part[k] >= trial[k];
    assign rem_next[k] = fit[k] ? REM_W'(part[k] - trial[k]) : part[k][REM_W-1:0];
    assign acc_next[k] = {acc_in[k][ROOT_W-2:0], fit[k]};
    assign rad_next[k] = {rad_in[k][SQ_W-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= rem_next[k];
        acc[k]  <= acc_next[k];
        rad[k]  <= rad_next[k];
        side[k] <= side_in[k];
      end
    end
  end

  assign root_valid = vld[ROOT_W-1];
  assign root_side  = side[ROOT_W-1];
  assign root       = acc[ROOT_W-1];

endmodule

// File: sv/spm_div.sv
module spm_div import spm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   num,
  input  logic [ROOT_W-1:0] den,
  output logic [ROOT_W-1:0] quo
);

  // The quotient is known to fit ROOT_W bits, so the upper half of the
  // dividend starts as the partial remainder and one bit is resolved per stage.
  logic [ROOT_W-1:0] rem      [ROOT_W];
  logic [ROOT_W-1:0] rem_in   [ROOT_W];
  logic [ROOT_W-1:0] rem_next [ROOT_W];
  logic [ROOT_W-1:0] low      [ROOT_W];
  logic [ROOT_W-1:0] low_in   [ROOT_W];
  logic [ROOT_W-1:0] acc      [ROOT_W];
  logic [ROOT_W-1:0] acc_in   [ROOT_W];
  logic [ROOT_W-1:0] dvs      [ROOT_W];
  logic [ROOT_W-1:0] dvs_in   [ROOT_W];
  logic [ROOT_W:0]   part     [ROOT_W];
  logic              fit      [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    if (k == 0) begin : g_first
      assign rem_in[k] = num[SQ_W-1 -: ROOT_W];
      assign low_in[k] = num[ROOT_W-1:0];
      assign acc_in[k] = '0;
      assign dvs_in[k] = den;
    end else begin : g_rest
      assign rem_in[k] = rem[k-1];
      assign low_in[k] = low[k-1];
      assign acc_in[k] = acc[k-1];
      assign dvs_in[k] = dvs[k-1];
    end

    assign part[k] = {rem_in[k], low_in[k][ROOT_W-1]};
    assign fit[k]  = part[k] >= {1'b0, dvs_in[k]};
    assign rem_next[k] = fit[k] ? ROOT_W'(part[k] - {1'b0, dvs_in[k]})
                                : part[k][ROOT_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= rem_next[k];
        low[k] <= {low_in[k][ROOT_W-2:0], 1'b0};
        acc[k] <= {acc_in[k][ROOT_W-2:0], fit[k]};
        dvs[k] <= dvs_in[k];
      end
    end
  end

  assign quo = acc[ROOT_W-1];

endmodule

// File: sv/shape_pair_mtv_core.sv
// Narrow-phase overlap test for two 2D shapes (box or circle each), giving a
// hit flag and the minimum translation vector that pushes shape b out of a.
// Input channel: pair_valid / pair_stall with the two shape descriptions; a
// word is taken at a rising edge with pair_valid high and pair_stall low.
// Output channel: mtv_valid / mtv_stall with hit, push_x and push_y; the
// output is a register and holds its word while mtv_stall is high.
// Throughput: one pair per clock cycle, sustained while pair_stall stays low.
// Pipeline: from acceptance to mtv_valid a word passes four front stages
// (offsets, penetrations, squares, hit test), a 33-stage square root that
// resolves one root bit per stage, one multiply stage, two 33-stage dividers
// (x and y) that resolve one quotient bit per stage, and the output register.
// Stall: while the output register is full and stalled, the pipeline keeps
// moving as long as its last stage is empty, so new pairs are still taken;
// once a result waits behind the output register, the whole pipeline
// freezes and pair_stall goes high. Nothing is dropped or repeated.
// Reset: rst is synchronous; it empties every stage and the output register.
`include "shape_pair_mtv_core_assert.svh"

module shape_pair_mtv_core import spm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pair_valid,
  output logic                          pair_stall,
  input  logic                          kind_a,
  input  logic signed [COORD_WIDTH-1:0] pos_a_x,
  input  logic signed [COORD_WIDTH-1:0] pos_a_y,
  input  logic [COORD_WIDTH-2:0]        size_a_x,
  input  logic [COORD_WIDTH-2:0]        size_a_y,
  input  logic                          kind_b,
  input  logic signed [COORD_WIDTH-1:0] pos_b_x,
  input  logic signed [COORD_WIDTH-1:0] pos_b_y,
  input  logic [COORD_WIDTH-2:0]        size_b_x,
  input  logic [COORD_WIDTH-2:0]        size_b_y,
  output logic                          mtv_valid,
  input  logic                          mtv_stall,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] push_x,
  output logic signed [COORD_WIDTH-1:0] push_y
);

  localparam logic [MAG_W-1:0] POS_LIMIT = {2'b00, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [MAG_W-1:0] NEG_LIMIT = {2'b01, {(COORD_WIDTH-1){1'b0}}};

  logic out_free, adv;

  logic              ds_valid;
  side_t             ds_side;
  logic [SQ_W-1:0]   ds;
  logic              root_valid;
  side_t             root_side;
  logic [ROOT_W-1:0] root;

  logic              m_valid;
  side_t             m_side;
  logic [ROOT_W-1:0] m_den;
  logic [SQ_W-1:0]   m_nx, m_ny, nx_next, ny_next;
  logic [MAG_W-1:0]  pen_m;

  logic              sl_valid [ROOT_W];
  side_t             sl_side  [ROOT_W];
  logic [ROOT_W-1:0] quo_x, quo_y;

  side_t                   fin;
  logic [MAG_W-1:0]        mag_out_x, mag_out_y;
  logic [COORD_WIDTH-1:0]  push_x_next, push_y_next;

  function automatic logic [COORD_WIDTH-1:0] sat_signed(input logic [MAG_W-1:0] m,
                                                       input logic neg_sign);
    logic [MAG_W-1:0] t;
    t = -m;
    if (!neg_sign) begin
      return (m > POS_LIMIT) ? POS_LIMIT[COORD_WIDTH-1:0] : m[COORD_WIDTH-1:0];
    end
    return (m > NEG_LIMIT) ? NEG_LIMIT[COORD_WIDTH-1:0] : t[COORD_WIDTH-1:0];
  endfunction

  // The pipeline moves unless a finished word is stuck behind a stalled output.
  assign out_free   = !mtv_valid || !mtv_stall;
  assign adv        = out_free || !sl_valid[ROOT_W-1];
  assign pair_stall = !adv;

  spm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .pair_valid (pair_valid),
    .kind_a     (kind_a),
    .pos_a_x    (pos_a_x),
    .pos_a_y    (pos_a_y),
    .size_a_x   (size_a_x),
    .size_a_y   (size_a_y),
    .kind_b     (kind_b),
    .pos_b_x    (pos_b_x),
    .pos_b_y    (pos_b_y),
    .size_b_x   (size_b_x),
    .size_b_y   (size_b_y),
    .ds_valid   (ds_valid),
    .ds_side    (ds_side),
    .ds         (ds)
  );

  spm_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .ds_valid   (ds_valid),
    .ds_side    (ds_side),
    .ds         (ds),
    .root_valid (root_valid),
    .root_side  (root_side),
    .root       (root)
  );

  // Penetration depth times each offset component, ahead of the divide.
  assign pen_m   = root_side.r - root;
  assign nx_next = SQ_W'(root_side.ex) * SQ_W'(pen_m);
  assign ny_next = SQ_W'(root_side.ey) * SQ_W'(pen_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_side <= root_side;
      m_den  <= root;
      m_nx   <= nx_next;
      m_ny   <= ny_next;
    end
  end

  spm_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (m_nx),
    .den (m_den),
    .quo (quo_x)
  );

  spm_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (m_ny),
    .den (m_den),
    .quo (quo_y)
  );

  // Control line that runs beside the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_W; k++) begin
        sl_valid[k] <= 1'b0;
      end
    end else if (adv) begin
      sl_valid[0] <= m_valid;
      for (int k = 1; k < ROOT_W; k++) begin
        sl_valid[k] <= sl_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sl_side[0] <= m_side;
      for (int k = 1; k < ROOT_W; k++) begin
        sl_side[k] <= sl_side[k-1];
      end
    end
  end

  assign fin = sl_side[ROOT_W-1];
  assign mag_out_x = fin.use_div ? quo_x : fin.dir_x;
  assign mag_out_y = fin.use_div ? quo_y : fin.dir_y;
  assign push_x_next = sat_signed(mag_out_x, fin.sx ^ fin.neg);
  assign push_y_next = sat_signed(mag_out_y, fin.sy ^ fin.neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      mtv_valid <= 1'b0;
    end else if (out_free) begin
      mtv_valid <= sl_valid[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      hit    <= fin.hit;
      push_x <= fin.hit ? push_x_next : '0;
      push_y <= fin.hit ? push_y_next : '0;
    end
  end

  `SPM_ASSERT_IMPL(a_no_hit_zero, mtv_valid && !hit, push_x == '0 && push_y == '0)
  `SPM_ASSERT_IMPL(a_load_word, out_free && sl_valid[ROOT_W-1], ##1 mtv_valid)
  `SPM_ASSERT_NEXT(a_reset_empty, rst, !mtv_valid && !sl_valid[ROOT_W-1])

endmodule

// File: test/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spm_pkg::*;

  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;
  localparam int   LATENCY     = 72;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   RANDOM_ITEMS = 1800;
  localparam int   HOLD_CYCLES = 400;

  typedef struct {
    logic                          ka;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic [COORD_WIDTH-2:0]        sax;
    logic [COORD_WIDTH-2:0]        say;
    logic                          kb;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic [COORD_WIDTH-2:0]        sbx;
    logic [COORD_WIDTH-2:0]        sby;
  } pair_t;

  typedef struct {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
  } push_t;

  class mtv_scoreboard;
    push_t pending[$];
    int    errors;
    int    hits;
    int    checked;

    function new();
      errors = 0;
      hits = 0;
      checked = 0;
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function logic [127:0] sq_sum(longint x, longint y);
      logic [127:0] mx;
      logic [127:0] my;
      mx = {64'b0, mag(x)};
      my = {64'b0, mag(y)};
      return mx * mx + my * my;
    endfunction

    function logic [63:0] floor_root(logic [127:0] n);
      logic [63:0]  res;
      logic [63:0]  c;
      logic [127:0] cc;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
        c = res | (64'd1 << b);
        cc = {64'b0, c} * {64'b0, c};
        if (cc <= n) res = c;
      end
      return res;
    endfunction

    function longint scale_to(longint v, logic [63:0] pen, logic [63:0] dlen);
      logic [127:0] m;
      m = ({64'b0, mag(v)} * {64'b0, pen}) / {64'b0, dlen};
      return v < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function longint clamp_to(longint v, longint h);
      return v < -h ? -h : (v > h ? h : v);
    endfunction

    // Push that moves the circle out of the box.
    function void circle_out_of_box(longint cx, longint cy, longint r, longint bx,
                                    longint by, longint hx, longint hy,
                                    output logic hit, output longint x,
                                    output longint y);
      longint       dx, dy, ex, ey, ox, oy;
      logic [127:0] ds;
      logic [63:0]  dlen;
      hit = 0;
      x = 0;
      y = 0;
      dx = cx - bx;
      dy = cy - by;
      ex = dx - clamp_to(dx, hx);
      ey = dy - clamp_to(dy, hy);
      ds = sq_sum(ex, ey);
      if (ds > {64'b0, mag(r)} * {64'b0, mag(r)}) return;
      hit = 1;
      if (ds != 0) begin
        dlen = floor_root(ds);
        x = scale_to(ex, 64'(r) - dlen, dlen);
        y = scale_to(ey, 64'(r) - dlen, dlen);
      end else begin
        ox = hx - longint'(mag(dx));
        oy = hy - longint'(mag(dy));
        if (ox < oy) x = dx < 0 ? -(ox + r) : ox + r;
        else y = dy < 0 ? -(oy + r) : oy + r;
      end
    endfunction

    function logic signed [COORD_WIDTH-1:0] saturate(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[COORD_WIDTH-1:0];
    endfunction

    function push_t predict(pair_t p);
      push_t        e;
      logic         h;
      longint       ax, ay, bx, by, sax, say, sbx, sby, dx, dy, pxl, pyl, x, y;
      logic [63:0]  rs, dlen;
      logic [127:0] ds;
      ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
      sax = {33'b0, p.sax}; say = {33'b0, p.say};
      sbx = {33'b0, p.sbx}; sby = {33'b0, p.sby};
      h = 0;
      x = 0;
      y = 0;
      dx = bx - ax;
      dy = by - ay;
      if (p.ka == KIND_BOX && p.kb == KIND_BOX) begin
        pxl = (sax + sbx) - longint'(mag(dx));
        pyl = (say + sby) - longint'(mag(dy));
        if (pxl > 0 && pyl > 0) begin
          h = 1;
          if (pxl < pyl) x = dx < 0 ? -pxl : pxl;
          else y = dy < 0 ? -pyl : pyl;
        end
      end else if (p.ka == KIND_CIRCLE && p.kb == KIND_CIRCLE) begin
        rs = 64'(sax + sbx);
        ds = sq_sum(dx, dy);
        if (ds < {64'b0, rs} * {64'b0, rs}) begin
          h = 1;
          if (ds == 0) begin
            x = longint'(rs);
          end else begin
            dlen = floor_root(ds);
            x = scale_to(dx, rs - dlen, dlen);
            y = scale_to(dy, rs - dlen, dlen);
          end
        end
      end else if (p.ka == KIND_CIRCLE) begin
        circle_out_of_box(ax, ay, sax, bx, by, sbx, sby, h, x, y);
        x = -x;
        y = -y;
      end else begin
        circle_out_of_box(bx, by, sbx, ax, ay, sax, say, h, x, y);
      end
      e.hit = h;
      e.px = h ? saturate(x) : '0;
      e.py = h ? saturate(y) : '0;
      return e;
    endfunction

    function void note_pair(pair_t p);
      pending.push_back(predict(p));
    endfunction

    function void check_push(logic h, logic signed [COORD_WIDTH-1:0] x,
                             logic signed [COORD_WIDTH-1:0] y);
      push_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word hit=%0b push=(%0d,%0d)", $realtime, h, x, y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h) hits++;
      if (h !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $realtime, e.hit, h);
        errors++;
      end
      if (x !== e.px) begin
        $display("%0t: push_x expected %0d actual %0d", $realtime, e.px, x);
        errors++;
      end
      if (y !== e.py) begin
        $display("%0t: push_y expected %0d actual %0d", $realtime, e.py, y);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic pair_valid;
  logic pair_stall;
  logic kind_a, kind_b;
  logic signed [COORD_WIDTH-1:0] pos_a_x, pos_a_y, pos_b_x, pos_b_y;
  logic [COORD_WIDTH-2:0] size_a_x, size_a_y, size_b_x, size_b_y;
  logic mtv_valid;
  logic mtv_stall;
  logic hit;
  logic signed [COORD_WIDTH-1:0] push_x, push_y;

  shape_pair_mtv_core u_dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_stall(pair_stall),
    .kind_a(kind_a), .pos_a_x(pos_a_x), .pos_a_y(pos_a_y),
    .size_a_x(size_a_x), .size_a_y(size_a_y),
    .kind_b(kind_b), .pos_b_x(pos_b_x), .pos_b_y(pos_b_y),
    .size_b_x(size_b_x), .size_b_y(size_b_y),
    .mtv_valid(mtv_valid), .mtv_stall(mtv_stall),
    .hit(hit), .push_x(push_x), .push_y(push_y)
  );

  mtv_scoreboard scoreboard = new();
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_request = 0;
  bit  hold_done = 0;
  int  pair_count = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("shape_pair_mtv_core test failed");
      $finish;
    end
  end

  // Result side: check accepted words, stall at random, and hold off once on request.
  initial begin
    int hold_left;
    hold_left = 0;
    mtv_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && mtv_valid && !mtv_stall) scoreboard.check_push(hit, push_x, push_y);
      if (hold_request && !hold_done && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        mtv_stall <= 1'b1;
      end else begin
        mtv_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic send_pair(pair_t p);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      pair_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair_valid <= 1'b1;
    kind_a <= p.ka; pos_a_x <= p.ax; pos_a_y <= p.ay;
    size_a_x <= p.sax; size_a_y <= p.say;
    kind_b <= p.kb; pos_b_x <= p.bx; pos_b_y <= p.by;
    size_b_x <= p.sbx; size_b_y <= p.sby;
    do @(posedge clk); while (pair_stall);
    scoreboard.note_pair(p);
    pair_count++;
  endtask

  function automatic pair_t make_pair(logic ka, longint ax, longint ay, longint sax,
                                      longint say, logic kb, longint bx, longint by,
                                      longint sbx, longint sby);
    pair_t p;
    p.ka = ka; p.ax = ax[31:0]; p.ay = ay[31:0]; p.sax = sax[30:0]; p.say = say[30:0];
    p.kb = kb; p.bx = bx[31:0]; p.by = by[31:0]; p.sbx = sbx[30:0]; p.sby = sby[30:0];
    return p;
  endfunction

  function automatic logic [30:0] rand_size();
    if ($urandom_range(0, 9) == 0) return 31'($urandom);
    return 31'($urandom >> $urandom_range(1, 31));
  endfunction

  // Mostly nearby pairs with random scale, so overlaps are common.
  function automatic pair_t rand_pair();
    pair_t p;
    p.ka = 1'($urandom_range(0, 1));
    p.kb = 1'($urandom_range(0, 1));
    p.ax = $urandom;
    p.ay = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      p.bx = $urandom;
      p.by = $urandom;
    end else begin
      p.bx = p.ax + ($signed($urandom) >>> $urandom_range(0, 31));
      p.by = p.ay + ($signed($urandom) >>> $urandom_range(0, 31));
    end
    if ($urandom_range(0, 15) == 0) p.by = p.ay;
    if ($urandom_range(0, 15) == 0) p.bx = p.ax;
    p.sax = rand_size();
    p.say = rand_size();
    p.sbx = rand_size();
    p.sby = rand_size();
    return p;
  endfunction

  initial begin
    longint mx;
    longint mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    rst = 1'b1;
    pair_valid = 1'b0;
    kind_a = KIND_BOX; kind_b = KIND_BOX;
    pos_a_x = '0; pos_a_y = '0; pos_b_x = '0; pos_b_y = '0;
    size_a_x = '0; size_a_y = '0; size_b_x = '0; size_b_y = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 83;
    // Box pairs: tie goes to y, x smaller, touching edge, apart, negative side.
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, 50, 50, 100, 100));
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, 150, 10, 100, 100));
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, 200, 0, 100, 100));
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, 0, 0, 100, 100));
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 100, KIND_BOX, -30, -170, 100, 100));
    send_pair(make_pair(KIND_BOX, mn, mn, 0, 0, KIND_BOX, mx, mx, 0, 0));
    send_pair(make_pair(KIND_BOX, mn, mn, mx, mx, KIND_BOX, mx, mx, mx, mx));
    // Circle pairs: coincident centers, touching, overlapping, huge radii.
    send_pair(make_pair(KIND_CIRCLE, 5, 5, 30, 0, KIND_CIRCLE, 5, 5, 40, 0));
    send_pair(make_pair(KIND_CIRCLE, 0, 0, 3, 0, KIND_CIRCLE, 3, 4, 2, 0));
    send_pair(make_pair(KIND_CIRCLE, 0, 0, 3, 0, KIND_CIRCLE, 3, 4, 3, 0));
    send_pair(make_pair(KIND_CIRCLE, mn, mn, mx, mx, KIND_CIRCLE, mx, mx, mx, mx));
    send_pair(make_pair(KIND_CIRCLE, 0, 0, mx, 0, KIND_CIRCLE, 0, 0, mx, 0));
    send_pair(make_pair(KIND_CIRCLE, 0, 0, 0, 0, KIND_CIRCLE, 0, 0, 0, 0));
    // Circle against box: center inside, touching a face, touching a corner, outside.
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 50, KIND_CIRCLE, 10, 20, 5, 0));
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 50, KIND_CIRCLE, -90, 0, 5, 0));
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 103, 104, 5, 0));
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 110, 0, 10, 0));
    send_pair(make_pair(KIND_BOX, 0, 0, 100, 100, KIND_CIRCLE, 107, 106, 12, 0));
    send_pair(make_pair(KIND_CIRCLE, 0, -3, 8, 0, KIND_BOX, 0, 0, 10, 10));
    send_pair(make_pair(KIND_CIRCLE, 120, 0, 30, 77, KIND_BOX, 0, 0, 100, 100));
    send_pair(make_pair(KIND_CIRCLE, 0, 0, 0, 0, KIND_BOX, 0, 0, 0, 0));
    send_pair(make_pair(KIND_CIRCLE, mx, mx, mx, mx, KIND_BOX, mn, mn, mx, mx));
    send_pair(make_pair(KIND_BOX, mn, mx, mx, 0, KIND_CIRCLE, mx, mn, mx, mx));

    repeat (RANDOM_ITEMS / 3) send_pair(rand_pair());
    send_idle_pct = 83;
    recv_idle_pct = 26;
    repeat (RANDOM_ITEMS / 3) send_pair(rand_pair());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1;
    repeat (RANDOM_ITEMS / 3) send_pair(rand_pair());
    pair_valid <= 1'b0;

    while (scoreboard.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Sent %0d shape pairs over box/circle mixes, extremes and three stall mixes.",
             pair_count);
    $display("Checked %0d results, %0d with a hit.", scoreboard.checked, scoreboard.hits);
    if (scoreboard.errors == 0 && scoreboard.pending.size() == 0) begin
      $display("shape_pair_mtv_core test passed");
    end else begin
      $display("shape_pair_mtv_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
